@@ sv/button_debounce_rearm_commander_unit_defines.svh @@
// Assertion macros shared by the debouncer RTL files.
// No dependencies; included by the files that carry assertions.
`ifndef BUTTON_DEBOUNCE_REARM_COMMANDER_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_REARM_COMMANDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BDRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BDRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bdrc_pkg.sv @@
// Types and constants of the pushbutton debouncer with rearm lockout.
// No dependencies; used by the interfaces and every RTL module.
package bdrc_pkg;

  localparam int POLL_W  = 10;
  localparam int TIMER_W = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Configuration values after reset
  localparam logic [POLL_W-1:0]  POLL_INTERVAL_RST = 10'd20;
  localparam logic [TIMER_W-1:0] DEBOUNCE_TIME_RST = 14'd80;
  localparam logic [TIMER_W-1:0] REARM_TIME_RST    = 14'd300;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_DEBOUNCE_TIME = 2'd1,
    REG_REARM_TIME    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [POLL_W-1:0]  poll_interval;
    logic [TIMER_W-1:0] debounce_time;
    logic [TIMER_W-1:0] rearm_time;
  } cfg_t;

  // One poll tick request
  typedef struct packed {
    logic inject_level;
    logic fill_level;
    logic motor_busy;
  } tick_t;

  // One result request
  typedef struct packed {
    logic inject_cmd;
    logic fill_cmd;
    logic stop_cmd;
    logic ignored_busy;
    logic inject_held;
    logic fill_held;
  } res_t;

  // Per-button events for one tick
  typedef struct packed {
    logic press;         // debounced press accepted, rearm expired
    logic held_release;  // debounced release of a latched press
    logic pressed;       // latched pressed state after this tick
  } btn_evt_t;

endpackage

@@ sv/bdrc_ifs.sv @@
// Valid/ready channel interfaces for tick, result and configuration requests.
// Depends on bdrc_pkg.
interface bdrc_tick_if;
  logic            valid;
  logic            ready;
  bdrc_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdrc_res_if;
  logic           valid;
  logic           ready;
  bdrc_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdrc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bdrc_pkg::CFG_INDEX_W-1:0]    index;
  logic [bdrc_pkg::CFG_DATA_W-1:0]     wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ sv/bdrc_cfg_regs.sv @@
// Configuration register file: poll interval, debounce time, rearm time.
// Depends on bdrc_pkg, bdrc_ifs and the assertion macro header.
`include "button_debounce_rearm_commander_unit_defines.svh"

module bdrc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  bdrc_cfg_if.sink       cfg,
  output bdrc_pkg::cfg_t regs
);

  logic wr;

  // Always take writes
  assign cfg.ready = 1'b1;
  assign wr = cfg.valid & cfg.ready;

  // Write the addressed register; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.poll_interval <= bdrc_pkg::POLL_INTERVAL_RST;
      regs.debounce_time <= bdrc_pkg::DEBOUNCE_TIME_RST;
      regs.rearm_time    <= bdrc_pkg::REARM_TIME_RST;
    end else if (wr) begin
      case (cfg.index)
        bdrc_pkg::REG_POLL_INTERVAL: begin
          regs.poll_interval <= cfg.wdata[bdrc_pkg::POLL_W-1:0];
        end
        bdrc_pkg::REG_DEBOUNCE_TIME: begin
          regs.debounce_time <= cfg.wdata[bdrc_pkg::TIMER_W-1:0];
        end
        bdrc_pkg::REG_REARM_TIME: begin
          regs.rearm_time <= cfg.wdata[bdrc_pkg::TIMER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  `BDRC_ASSERT_NEXT(a_poll_write, clk, rst,
    wr && cfg.index == bdrc_pkg::REG_POLL_INTERVAL,
    regs.poll_interval == $past(cfg.wdata[bdrc_pkg::POLL_W-1:0]),
    "poll interval write lost")

endmodule

@@ sv/bdrc_button.sv @@
// One button: raw level tracking, debounce timer, rearm countdown, press latch.
// Depends on bdrc_pkg.
module bdrc_button (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             level,
  input  bdrc_pkg::cfg_t   regs,
  output bdrc_pkg::btn_evt_t evt
);

  logic                         last_raw, last_raw_next;
  logic                         stable, stable_next;
  logic [bdrc_pkg::TIMER_W-1:0] elapsed, elapsed_next;
  logic [bdrc_pkg::TIMER_W-1:0] rearm, rearm_next;
  logic [bdrc_pkg::TIMER_W-1:0] rearm_dec;
  logic [bdrc_pkg::TIMER_W-1:0] poll_ext;
  logic [bdrc_pkg::TIMER_W:0]   sum;
  logic                         raw, settled;

  assign raw      = ~level;
  assign poll_ext = {{(bdrc_pkg::TIMER_W-bdrc_pkg::POLL_W){1'b0}}, regs.poll_interval};
  assign sum      = {1'b0, elapsed} + {1'b0, poll_ext};

  always_comb begin
    // Restart debounce on a change, else accumulate up to the threshold
    last_raw_next = raw;
    if (raw != last_raw) begin
      elapsed_next = '0;
    end else if (elapsed < regs.debounce_time) begin
      elapsed_next = sum[bdrc_pkg::TIMER_W] ? bdrc_pkg::TIMER_MAX
                                            : sum[bdrc_pkg::TIMER_W-1:0];
    end else begin
      elapsed_next = elapsed;
    end

    // Count rearm down to zero
    rearm_dec = (rearm > poll_ext) ? rearm - poll_ext : '0;

    settled = elapsed_next >= regs.debounce_time;
    evt.press        = settled & raw & ~stable & (rearm_dec == '0);
    evt.held_release = settled & ~raw & stable;

    // Latch press, load rearm; clear latch on settled release
    stable_next = stable;
    rearm_next  = rearm_dec;
    if (evt.press) begin
      stable_next = 1'b1;
      rearm_next  = regs.rearm_time;
    end else if (settled & ~raw) begin
      stable_next = 1'b0;
    end
    evt.pressed = stable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b0;
      stable   <= 1'b0;
      elapsed  <= '0;
      rearm    <= '0;
    end else if (step) begin
      last_raw <= last_raw_next;
      stable   <= stable_next;
      elapsed  <= elapsed_next;
      rearm    <= rearm_next;
    end
  end

endmodule

@@ sv/bdrc_cmd.sv @@
// Command decision: inject, fill, stop and busy-drop flags, fill hold flag.
// Depends on bdrc_pkg.
module bdrc_cmd (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               motor_busy,
  input  bdrc_pkg::btn_evt_t inj,
  input  bdrc_pkg::btn_evt_t fil,
  output bdrc_pkg::res_t     res
);

  logic holding, holding_next;
  logic fill_busy;

  always_comb begin
    res = '0;
    holding_next = holding;

    // Inject button first
    if (inj.press) begin
      if (motor_busy) begin
        res.ignored_busy = 1'b1;
      end else begin
        res.inject_cmd = 1'b1;
      end
    end

    // An inject issued this tick keeps the motor busy for fill
    fill_busy = motor_busy | res.inject_cmd;
    if (fil.press) begin
      if (fill_busy) begin
        res.ignored_busy = 1'b1;
      end else begin
        res.fill_cmd = 1'b1;
        holding_next = 1'b1;
      end
    end else if (fil.held_release && holding) begin
      holding_next = 1'b0;
      res.stop_cmd = fill_busy;
    end

    res.inject_held = inj.pressed;
    res.fill_held   = fil.pressed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
    end else if (step) begin
      holding <= holding_next;
    end
  end

endmodule

@@ sv/button_debounce_rearm_commander_unit.sv @@
// Two-button debouncer with rearm lockout that turns poll ticks into motor
// commands. Each tick request carries the active-low inject and fill levels
// and the motor busy flag and yields exactly one result request. A tick is
// taken in every cycle when the result side keeps up; it passes an input
// register and then a result register before its result request is valid.
// The configuration channel is always ready and writes poll_interval
// (index 0), debounce_time (1) and rearm_time (2); other indexes are dropped.
// After reset the registers hold 20, 80 and 300 and both buttons are released.
`include "button_debounce_rearm_commander_unit_defines.svh"

module button_debounce_rearm_commander_unit (
  input  logic       clk,
  input  logic       rst,
  bdrc_tick_if.sink  tick,
  bdrc_res_if.source result,
  bdrc_cfg_if.sink   cfg
);

  bdrc_pkg::cfg_t     regs;
  bdrc_pkg::tick_t    in_data;
  bdrc_pkg::res_t     res_data;
  bdrc_pkg::res_t     res_calc;
  bdrc_pkg::btn_evt_t inj_evt, fil_evt;
  logic               in_valid, res_valid;
  logic               adv, step;

  bdrc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Advance when the result register is empty or being taken
  assign adv        = ~res_valid | result.ready;
  assign step       = in_valid & adv;
  assign tick.ready = ~in_valid | adv;

  // Hold the tick request in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_data <= tick.data;
    end
  end

  bdrc_button u_inject (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .level (in_data.inject_level),
    .regs  (regs),
    .evt   (inj_evt)
  );

  bdrc_button u_fill (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .level (in_data.fill_level),
    .regs  (regs),
    .evt   (fil_evt)
  );

  bdrc_cmd u_cmd (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .motor_busy (in_data.motor_busy),
    .inj        (inj_evt),
    .fil        (fil_evt),
    .res        (res_calc)
  );

  // Register the result request
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= res_calc;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

  `BDRC_ASSERT_IMPL(a_one_cmd, clk, rst,
    res_valid && res_data.inject_cmd, !res_data.fill_cmd,
    "inject and fill issued in one tick")
  `BDRC_ASSERT_IMPL(a_stop_not_fill, clk, rst,
    res_valid && res_data.stop_cmd, !res_data.fill_cmd && !res_data.fill_held,
    "stop issued with fill pressed")
  `BDRC_ASSERT_IMPL(a_inject_held, clk, rst,
    res_valid && res_data.inject_cmd, res_data.inject_held,
    "inject issued without latched press")
  `BDRC_ASSERT_IMPL(a_fill_held, clk, rst,
    res_valid && res_data.fill_cmd, res_data.fill_held,
    "fill issued without latched press")
  `BDRC_ASSERT_NEXT(a_step_fills, clk, rst,
    step, res_valid,
    "processed tick did not reach result register")

endmodule

@@ tb/button_debounce_rearm_commander_unit_test.sv @@
// Self-checking bench for the two-button debouncer with rearm lockout.
// Depends on bdrc_pkg and the channel interfaces in bdrc_ifs.sv; drives a
// directed table, then random level runs, checked against a local predictor or typed outcomes.
module button_debounce_rearm_commander_unit_test;
  import bdrc_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int BTN_INJECT      = 0;
  localparam int BTN_FILL        = 1;

  // Pin levels are active low
  localparam logic UP   = 1'b1;
  localparam logic DOWN = 1'b0;

  // Table rows either trust the predictor or carry a typed outcome
  localparam bit PREDICT = 1'b0;
  localparam bit KNOWN   = 1'b1;

  // Index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] REG_UNKNOWN = 2'd3;

  typedef enum logic {STEP_TICK, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t              kind;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   wdata;
    tick_t                   tick;
    logic                    known;
    res_t                    want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdrc_tick_if tick_ch ();
  bdrc_res_if  result_ch ();
  bdrc_cfg_if  cfg_ch ();

  button_debounce_rearm_commander_unit dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Predictor copy of configuration and per-button state
  logic [POLL_W-1:0]  poll_ms;
  logic [TIMER_W-1:0] settle_limit_ms;
  logic [TIMER_W-1:0] lockout_load_ms;
  logic               last_down [2];
  logic               held [2];
  logic [TIMER_W-1:0] settle_ms [2];
  logic [TIMER_W-1:0] lockout_ms [2];
  logic               filling;

  res_t  pending_commands [$];
  step_t steps [$];
  int    mismatches   = 0;
  int    stall_cycles = 0;
  bit    idle_on      = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance both buttons by one poll tick and return the outcome
  function automatic res_t debounce_tick(input tick_t t);
    res_t               r;
    logic               down;
    logic               busy;
    logic [TIMER_W-1:0] poll_ext;
    int unsigned        sum;
    int                 b;
    r = '0;
    poll_ext = {{(TIMER_W-POLL_W){1'b0}}, poll_ms};
    for (b = 0; b < 2; b++) begin
      down = (b == BTN_INJECT) ? !t.inject_level : !t.fill_level;
      busy = t.motor_busy | r.inject_cmd;
      // Restart the debounce timer on a level change, else grow it
      if (down != last_down[b]) begin
        last_down[b] = down;
        settle_ms[b] = '0;
      end else if (settle_ms[b] < settle_limit_ms) begin
        sum = 32'(settle_ms[b]) + 32'(poll_ext);
        settle_ms[b] = (sum > 32'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_W-1:0];
      end
      if (lockout_ms[b] > poll_ext) begin
        lockout_ms[b] = lockout_ms[b] - poll_ext;
      end else begin
        lockout_ms[b] = '0;
      end
      if (settle_ms[b] >= settle_limit_ms) begin
        if (down && !held[b] && lockout_ms[b] == '0) begin
          held[b] = 1'b1;
          lockout_ms[b] = lockout_load_ms;
          if (busy) begin
            r.ignored_busy = 1'b1;
          end else if (b == BTN_INJECT) begin
            r.inject_cmd = 1'b1;
          end else begin
            r.fill_cmd = 1'b1;
            filling = 1'b1;
          end
        end else if (!down) begin
          // Stop only a fill that was started and is still running
          if (held[b] && b == BTN_FILL && filling) begin
            filling = 1'b0;
            if (busy) begin
              r.stop_cmd = 1'b1;
            end
          end
          held[b] = 1'b0;
        end
      end
    end
    r.inject_held = held[BTN_INJECT];
    r.fill_held = held[BTN_FILL];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endfunction

  // Hold ticks until every outcome is back and the pipeline is empty
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_POLL_INTERVAL: poll_ms = val[POLL_W-1:0];
      REG_DEBOUNCE_TIME: settle_limit_ms = val[TIMER_W-1:0];
      REG_REARM_TIME:    lockout_load_ms = val[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  // Send one tick request, then queue its outcome
  task automatic send_tick(input tick_t t, input logic known, input res_t want);
    res_t predicted;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    predicted = debounce_tick(t);
    pending_commands.push_back(known ? want : predicted);
  endtask

  task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.index = idx;
    s.wdata = val;
    steps.push_back(s);
  endtask

  task automatic add_tick(input logic inj, input logic fil, input logic busy,
                          input logic known, input res_t want);
    step_t s;
    s = '0;
    s.kind = STEP_TICK;
    s.tick.inject_level = inj;
    s.tick.fill_level = fil;
    s.tick.motor_busy = busy;
    s.known = known;
    s.want = want;
    steps.push_back(s);
  endtask

  // Stall the result side in random bursts
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  // Compare each result request with the oldest outcome
  always @(posedge clk) begin : check_result
    res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_commands.size() == 0) begin
        $error("result request with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_commands.pop_front();
        check_field("inject_cmd", want.inject_cmd, result_ch.data.inject_cmd);
        check_field("fill_cmd", want.fill_cmd, result_ch.data.fill_cmd);
        check_field("stop_cmd", want.stop_cmd, result_ch.data.stop_cmd);
        check_field("ignored_busy", want.ignored_busy, result_ch.data.ignored_busy);
        check_field("inject_held", want.inject_held, result_ch.data.inject_held);
        check_field("fill_held", want.fill_held, result_ch.data.fill_held);
      end
    end
  end

  // Drop the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("button_debounce_rearm_commander_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    int    ph;
    int    n;
    int    b;
    int    settle_ticks;
    int    run_left [2];
    int    busy_left;
    logic  lvl [2];
    logic  busy;
    tick_t t;
    int    poll_set [PHASES];
    int    deb_set [PHASES];
    int    rearm_set [PHASES];

    tick_ch.valid <= 1'b0;
    tick_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.wdata <= '0;

    poll_ms = POLL_INTERVAL_RST;
    settle_limit_ms = DEBOUNCE_TIME_RST;
    lockout_load_ms = REARM_TIME_RST;
    for (b = 0; b < 2; b++) begin
      last_down[b] = 1'b0;
      held[b] = 1'b0;
      settle_ms[b] = '0;
      lockout_ms[b] = '0;
    end
    filling = 1'b0;

    // Reset-default timing: press inject long enough to pass debounce
    add_tick(UP, UP, 1'b0, KNOWN, 6'b000000);
    repeat (5) add_tick(DOWN, UP, 1'b0, PREDICT, '0);
    // No debounce, no rearm, a tick of 1000
    add_write(REG_DEBOUNCE_TIME, 14'd0);
    add_write(REG_REARM_TIME, 14'd0);
    add_write(REG_POLL_INTERVAL, 14'd1000);
    add_tick(UP, UP, 1'b0, KNOWN, 6'b000000);
    // Inject command makes the fill press in the same tick count as busy
    add_tick(DOWN, DOWN, 1'b0, KNOWN, 6'b100111);
    // Fill released without a running fill: no stop
    add_tick(UP, UP, 1'b0, KNOWN, 6'b000000);
    add_tick(UP, DOWN, 1'b0, KNOWN, 6'b010001);
    add_tick(UP, UP, 1'b1, KNOWN, 6'b001000);
    add_tick(UP, DOWN, 1'b0, KNOWN, 6'b010001);
    add_tick(UP, UP, 1'b0, KNOWN, 6'b000000);
    // Fill press while busy leaves the running-fill flag alone
    add_tick(UP, DOWN, 1'b1, KNOWN, 6'b000101);
    add_tick(UP, UP, 1'b1, KNOWN, 6'b000000);
    add_tick(DOWN, UP, 1'b1, KNOWN, 6'b000110);
    add_tick(UP, UP, 1'b1, KNOWN, 6'b000000);
    // A long rearm lockout blocks a quick second press
    add_write(REG_REARM_TIME, 14'd10000);
    add_tick(DOWN, UP, 1'b0, KNOWN, 6'b100010);
    add_tick(UP, UP, 1'b0, PREDICT, '0);
    add_tick(DOWN, UP, 1'b0, PREDICT, '0);
    // Upper bits masked away give a zero poll interval; stray index dropped
    add_write(REG_POLL_INTERVAL, 14'h3C00);
    add_write(REG_DEBOUNCE_TIME, 14'd1);
    add_write(REG_UNKNOWN, 14'h3FFF);
    add_tick(UP, UP, 1'b0, PREDICT, '0);
    add_tick(UP, DOWN, 1'b1, PREDICT, '0);
    add_tick(UP, DOWN, 1'b1, PREDICT, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (steps[i]) begin
      if (steps[i].kind == STEP_WRITE) begin
        set_reg(steps[i].index, steps[i].wdata);
      end else begin
        send_tick(steps[i].tick, steps[i].known, steps[i].want);
      end
    end

    // Timing sets for the random phases: defaults, extremes, then random
    poll_set[0] = int'(POLL_INTERVAL_RST);
    deb_set[0] = int'(DEBOUNCE_TIME_RST);
    rearm_set[0] = int'(REARM_TIME_RST);
    poll_set[1] = 1;
    deb_set[1] = 0;
    rearm_set[1] = 0;
    poll_set[2] = 1000;
    deb_set[2] = 10000;
    rearm_set[2] = 10000;
    poll_set[3] = 1000;
    deb_set[3] = int'(TIMER_MAX);
    rearm_set[3] = int'(TIMER_MAX);
    poll_set[4] = 0;
    deb_set[4] = 0;
    rearm_set[4] = 0;
    for (ph = 5; ph < PHASES; ph++) begin
      poll_set[ph] = $urandom_range(1, 1000);
      deb_set[ph] = poll_set[ph] * $urandom_range(0, 6) + $urandom_range(0, poll_set[ph] - 1);
      rearm_set[ph] = poll_set[ph] * $urandom_range(0, 8);
      if (deb_set[ph] > 10000) deb_set[ph] = 10000;
      if (rearm_set[ph] > 10000) rearm_set[ph] = 10000;
    end

    lvl[BTN_INJECT] = UP;
    lvl[BTN_FILL] = UP;
    run_left[BTN_INJECT] = 0;
    run_left[BTN_FILL] = 0;
    busy_left = 0;
    busy = 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      set_reg(REG_POLL_INTERVAL, CFG_DATA_W'(poll_set[ph]));
      set_reg(REG_DEBOUNCE_TIME, CFG_DATA_W'(deb_set[ph]));
      set_reg(REG_REARM_TIME, CFG_DATA_W'(rearm_set[ph]));
      settle_ticks = (poll_set[ph] == 0) ? 1 : deb_set[ph] / poll_set[ph] + 2;
      if (settle_ticks > 24) settle_ticks = 24;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Quiet stretch at the start of each phase and the whole last phase
        idle_on = (n >= 20) && (ph < PHASES - 1);
        if (n == ITEMS_PER_PHASE / 2) wait_drained();
        // Hold each level for a run, mostly long enough to be accepted
        for (b = 0; b < 2; b++) begin
          if (run_left[b] == 0) begin
            lvl[b] = ~lvl[b];
            run_left[b] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(1, 2 * settle_ticks + 2);
          end
          run_left[b]--;
        end
        if (busy_left == 0) begin
          busy = ($urandom_range(0, 2) == 0);
          busy_left = $urandom_range(1, 10);
        end
        busy_left--;
        t.inject_level = lvl[BTN_INJECT];
        t.fill_level = lvl[BTN_FILL];
        t.motor_busy = busy;
        send_tick(t, PREDICT, '0);
      end
    end

    idle_on = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_commands.size() == 0) begin
      $display("button_debounce_rearm_commander_unit_test: PASS");
    end else begin
      $display("button_debounce_rearm_commander_unit_test: FAIL");
    end
    $finish;
  end

endmodule
